>>> rtl/mbps_pkg.sv
package mbps_pkg;

    // window depth default and fixed capacity of the pattern registers
    localparam int PATTERN_MAX_DEF = 32;
    localparam int PAT_REG_BYTES   = 32;
    localparam int PAT_REG_W       = 64;
    localparam int ADDR_W          = 64;
    localparam int MASK_W          = 32;
    localparam int LEN_W           = 6;
    localparam int CFG_IDX_W       = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT0  = 3'd0,
        CFG_PAT1  = 3'd1,
        CFG_PAT2  = 3'd2,
        CFG_PAT3  = 3'd3,
        CFG_MASK  = 3'd4,
        CFG_LEN   = 3'd5,
        CFG_START = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [PAT_REG_BYTES*8-1:0] pattern;
        logic [MASK_W-1:0]          mask;
        logic [LEN_W-1:0]           length;
        logic [ADDR_W-1:0]          start;
    } t_cfg;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] addr;
    } t_result;

endpackage

>>> rtl/mbps_cfg.sv
module mbps_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [mbps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mbps_pkg::ADDR_W-1:0]    i_cfg_data,
    output mbps_pkg::t_cfg                 o_cfg
);
    import mbps_pkg::*;

    t_cfg r_cfg;

    // register file, write-only; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index) inside
                CFG_PAT0, CFG_PAT1, CFG_PAT2, CFG_PAT3: begin
                    r_cfg.pattern[i_cfg_index[1:0]*PAT_REG_W +: PAT_REG_W] <= i_cfg_data;
                end
                CFG_MASK:  r_cfg.mask   <= i_cfg_data[MASK_W-1:0];
                CFG_LEN:   r_cfg.length <= i_cfg_data[LEN_W-1:0];
                CFG_START: r_cfg.start  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/mbps_match.sv
module mbps_match #(
    parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  mbps_pkg::t_cfg    i_cfg,
    output logic              o_emit,
    output mbps_pkg::t_result o_result
);
    import mbps_pkg::*;

    localparam int CMP_N  = (PATTERN_MAX < PAT_REG_BYTES) ? PATTERN_MAX : PAT_REG_BYTES;
    localparam int WIN_IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int PAD_N  = 2 ** WIN_IW;
    localparam logic [LEN_W:0] MAX_LEN = (LEN_W+1)'(CMP_N);

    logic [7:0]        r_win [PATTERN_MAX];
    logic [7:0]        n_win [PATTERN_MAX];
    logic [7:0]        w_pad [PAD_N];
    logic [ADDR_W-1:0] r_offset;
    logic [ADDR_W-1:0] n_offset;
    logic              r_done;
    logic              n_done;
    logic [CMP_N-1:0]  w_bad;
    logic              w_len_ok;
    logic              w_hit;
    logic [ADDR_W-1:0] w_len_ext;

    // window after the new byte: newest at index 0, padded for indexing
    always_comb begin
        n_win[0] = i_byte;
        for (int i = 1; i < PATTERN_MAX; i++) begin
            n_win[i] = r_win[i-1];
        end
        for (int i = 0; i < PAD_N; i++) begin
            w_pad[i] = (i < PATTERN_MAX) ? n_win[i] : 8'h00;
        end
    end

    // masked per-byte compare; pattern byte j meets window entry len-1-j
    always_comb begin
        logic [LEN_W-1:0] idx;
        logic             care;
        for (int j = 0; j < CMP_N; j++) begin
            idx      = i_cfg.length - LEN_W'(1) - LEN_W'(j);
            care     = i_cfg.mask[j] && (LEN_W'(j) < i_cfg.length);
            w_bad[j] = care && (w_pad[idx[WIN_IW-1:0]] != i_cfg.pattern[j*8 +: 8]);
        end
    end

    // saturating byte count of the scan, counting the current byte
    assign n_offset  = (r_offset == '1) ? r_offset : r_offset + ADDR_W'(1);
    assign w_len_ext = ADDR_W'(i_cfg.length);
    assign w_len_ok  = (i_cfg.length != '0) && ({1'b0, i_cfg.length} <= MAX_LEN);
    assign w_hit     = !r_done && w_len_ok && (i_cfg.start != '0) &&
                       (n_offset >= w_len_ext) && (w_bad == '0);

    assign n_done = i_last ? 1'b0 : (r_done || w_hit);

    // result for this beat: first match, or not-found at region end
    assign o_emit         = w_hit || (i_last && !r_done);
    assign o_result.found = w_hit;
    assign o_result.addr  = w_hit ? (i_cfg.start + (n_offset - w_len_ext)) : '0;

    // scan state; window bytes are only read after being refilled in a scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_done   <= 1'b0;
        end else if (i_accept) begin
            r_offset <= i_last ? '0 : n_offset;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_win <= n_win;
        end
    end

endmodule

>>> rtl/mbps_out_reg.sv
module mbps_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  mbps_pkg::t_result i_result,
    input  logic              i_take,
    output logic              o_valid,
    output mbps_pkg::t_result o_result
);
    import mbps_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // holds a result until the downstream beat completes
    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> rtl/masked_byte_pattern_search.sv
// Channel      Dir  Signals                          Payload
// s_axis       in   s_axis_tvalid/tready/tdata/tlast tdata[7:0] data_byte, tlast last_byte
// m_axis       out  m_axis_tvalid/tready/tdata/tuser tdata[63:0] match_address, tuser found
// cfg          in   i_cfg_valid/o_cfg_ready          i_cfg_index register, i_cfg_data value
//
// One byte per cycle: window shift, masked compare and address add finish in
// the accept cycle and land in the result register.
// The result register sets the rate: a new beat is taken whenever it is empty
// or being drained in the same cycle, so a stalled result stops the input.
// Synchronous active-low reset clears the scan state, result valid and
// configuration; no clearing pass is needed.
module masked_byte_pattern_search #(
    parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] data_byte
    input  logic                           s_axis_tlast,   // last_byte
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [mbps_pkg::ADDR_W-1:0]    m_axis_tdata,   // [63:0] match_address
    output logic                           m_axis_tuser,   // [0] found
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mbps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mbps_pkg::ADDR_W-1:0]    i_cfg_data
);
    import mbps_pkg::*;

    t_cfg    w_cfg;
    t_result w_result;
    t_result w_out;
    logic    w_accept;
    logic    w_emit;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    mbps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    mbps_match #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_match (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_cfg    (w_cfg),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    mbps_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept && w_emit),
        .i_result (w_result),
        .i_take   (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_result (w_out)
    );

    assign m_axis_tdata = w_out.addr;
    assign m_axis_tuser = w_out.found;

endmodule

>>> rtl/mbps_checker.sv
module mbps_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           s_axis_tready,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready,
    input logic [mbps_pkg::ADDR_W-1:0]    m_axis_tdata,
    input logic                           m_axis_tuser
);
    import mbps_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // a not-found result carries a zero address
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("not-found result with nonzero address");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // input is never held off while the result register is free
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("input stalled with free result register");

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
